[design/counter_mode_256bit_block_cipher_assert.svh]
// Assertion macros for the counter-mode 256-bit block cipher.
// Used by the top level; no other dependencies.
`ifndef COUNTER_MODE_256BIT_BLOCK_CIPHER_ASSERT_SVH
`define COUNTER_MODE_256BIT_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define CMB_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
`define CMB_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define CMB_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define CMB_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

[design/cmb_pkg.sv]
// Shared types, codes, constants and datapath functions of the block cipher.
// No dependencies.
package cmb_pkg;

    localparam int DEF_MAX_ROUNDS = 16;

    localparam logic [1:0] FUNC_ENC = 2'd0;
    localparam logic [1:0] FUNC_DEC = 2'd1;
    localparam logic [1:0] FUNC_KEY = 2'd2;

    localparam logic [2:0] REG_ROUNDS = 3'd0;
    localparam logic [2:0] REG_MASK0  = 3'd1;
    localparam logic [2:0] REG_MASK1  = 3'd2;
    localparam logic [2:0] REG_MASK2  = 3'd3;
    localparam logic [2:0] REG_MASK3  = 3'd4;

    localparam logic [63:0] DIFF_C0 = 64'ha5a5a5a578787878;
    localparam logic [63:0] DIFF_C1 = 64'h2d2d2d2d1e1e1e1e;
    localparam logic [63:0] DIFF_C2 = 64'h969696964b4b4b4b;
    localparam logic [63:0] DIFF_C3 = 64'h3c3c3c3cf0f0f0f0;

    typedef logic [3:0][63:0] quad_t;

    typedef struct packed {
        logic  dec;
        quad_t blk;
        quad_t wht;
    } pipe_t;

    function automatic logic [63:0] rol64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] t;
        t = {x, x} << r;
        return t[127:64];
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] t;
        t = {x, x} << r;
        return t[63:32];
    endfunction

    function automatic logic [15:0] rol16(input logic [15:0] x, input logic [3:0] r);
        logic [31:0] t;
        t = {x, x} << r;
        return t[31:16];
    endfunction

    function automatic quad_t lanes16(input quad_t w, input logic [63:0] s, input logic inv);
        logic [255:0] f;
        logic [255:0] o;
        logic [3:0]   a;
        f = w;
        o = '0;
        for (int k = 0; k < 16; k++)
        begin
            a = s[4*k +: 4];
            if (inv)
            begin
                a = 4'd0 - a;
            end
            o[16*k +: 16] = rol16(f[16*k +: 16], a);
        end
        return quad_t'(o);
    endfunction

    function automatic quad_t lanes32(input quad_t w, input logic [63:0] s, input logic inv);
        logic [255:0] f;
        logic [255:0] o;
        logic [4:0]   a;
        f = w;
        o = '0;
        for (int k = 0; k < 8; k++)
        begin
            a = s[5*k +: 5];
            if (inv)
            begin
                a = 5'd0 - a;
            end
            o[32*k +: 32] = rol32(f[32*k +: 32], a);
        end
        return quad_t'(o);
    endfunction

    function automatic quad_t lanes64(input quad_t w, input logic [63:0] s, input logic inv);
        quad_t      o;
        logic [5:0] a;
        for (int k = 0; k < 4; k++)
        begin
            a = s[6*k +: 6];
            if (inv)
            begin
                a = 6'd0 - a;
            end
            o[k] = rol64(w[k], a);
        end
        return o;
    endfunction

    function automatic quad_t arx_fwd(input quad_t w, input int xi, input int yi,
                                      input logic [63:0] k);
        quad_t o;
        o = w;
        o[xi] = (rol64(w[xi], 6'd56) + w[yi]) ^ k;
        o[yi] = rol64(w[yi], 6'd3) ^ o[xi];
        return o;
    endfunction

    function automatic quad_t arx_inv(input quad_t w, input int xi, input int yi,
                                      input logic [63:0] k);
        quad_t o;
        o = w;
        o[yi] = rol64(w[yi] ^ w[xi], 6'd61);
        o[xi] = rol64((w[xi] ^ k) - o[yi], 6'd8);
        return o;
    endfunction

    function automatic quad_t mul_fwd(input quad_t a);
        quad_t t;
        t[0] = 64'd0 - (a[0] << 1) - a[0] - a[1] - (a[3] << 2) - a[3];
        t[1] = (a[0] << 3) - a[0] + (a[1] << 1) + a[1] + a[2] + (a[3] << 3) + (a[3] << 2);
        t[2] = 64'd0 - (a[0] << 1) - a[1] - (a[3] << 2);
        t[3] = (a[0] << 3) + a[0] + (a[1] << 2) + a[2] + (a[3] << 4) - a[3];
        return t;
    endfunction

    function automatic quad_t mul_inv(input quad_t a);
        quad_t t;
        t[0] = 64'd0 - a[0] - a[1] + (a[2] << 1) + a[3];
        t[1] = (a[0] << 1) - (a[1] << 1) - a[2] + (a[3] << 1);
        t[2] = a[0] + (a[1] << 1) + a[2] - a[3];
        t[3] = a[1] - a[2] - a[3];
        return t;
    endfunction

    function automatic quad_t quad_add(input quad_t a, input quad_t b);
        quad_t o;
        for (int j = 0; j < 4; j++)
        begin
            o[j] = a[j] + b[j];
        end
        return o;
    endfunction

    function automatic quad_t quad_sub(input quad_t a, input quad_t b);
        quad_t o;
        for (int j = 0; j < 4; j++)
        begin
            o[j] = a[j] - b[j];
        end
        return o;
    endfunction

    // one diffusion round with word a at position i, b, c, d following
    function automatic quad_t diffuse(input quad_t w, input logic [1:0] i,
                                      input logic [5:0] r, input logic [63:0] t);
        quad_t       o;
        logic [1:0]  ib;
        logic [1:0]  ic;
        logic [1:0]  id;
        logic [63:0] na;
        ib = i + 2'd1;
        ic = i + 2'd2;
        id = i + 2'd3;
        na = w[i] + rol64(w[ib], 6'd5) - w[ib];
        o = w;
        o[ic] = w[ic] ^ (w[id] + t);
        o[ib] = rol64(w[ib], 6'd8);
        o[id] = w[id] + na;
        o[i]  = rol64(na, r);
        return o;
    endfunction

endpackage

[design/cmb_round.sv]
// One cipher round as two pipeline stages, encrypt or decrypt per item.
// Depends on cmb_pkg.
module cmb_round
    import cmb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  in_valid,
    input  pipe_t in_data,
    input  quad_t key_enc,
    input  quad_t key_dec,
    input  logic  act_enc,
    input  logic  act_dec,
    output logic  out_valid,
    output pipe_t out_data,
    output logic  busy
);

    logic  va_reg;
    logic  vb_reg;
    pipe_t da_reg;
    pipe_t da_next;
    pipe_t db_reg;
    pipe_t db_next;

    always_comb
    begin
        quad_t k;
        quad_t s;
        quad_t b;
        k = in_data.dec ? key_dec : key_enc;
        s = in_data.wht ^ k;
        b = in_data.blk;
        da_next = in_data;
        if (!in_data.dec)
        begin
            b = lanes16(b, s[1], 1'b0);
            b = lanes64(b, s[2], 1'b0);
            b = arx_fwd(b, 0, 1, k[0]);
            b = arx_fwd(b, 2, 3, k[1]);
            b = lanes32(b, s[2] >> 24, 1'b0);
            b = lanes64(b, s[0], 1'b0);
            b = arx_fwd(b, 2, 1, k[3]);
            b = arx_fwd(b, 0, 3, k[2]);
            if (act_enc)
            begin
                da_next.blk = b;
            end
        end
        else
        begin
            b = mul_inv(quad_sub(b, k));
            b = lanes32(b, s[0] >> 24, 1'b1);
            b = lanes16(b, s[3], 1'b1);
            if (act_dec)
            begin
                da_next.blk = b;
            end
        end
    end

    always_comb
    begin
        quad_t k;
        quad_t s;
        quad_t b;
        k = da_reg.dec ? key_dec : key_enc;
        s = da_reg.wht ^ k;
        b = da_reg.blk;
        db_next = da_reg;
        if (!da_reg.dec)
        begin
            b = lanes16(b, s[3], 1'b0);
            b = lanes32(b, s[0] >> 24, 1'b0);
            b = quad_add(mul_fwd(b), k);
            if (act_enc)
            begin
                db_next.blk = b;
            end
        end
        else
        begin
            b = arx_inv(b, 0, 3, k[2]);
            b = arx_inv(b, 2, 1, k[3]);
            b = lanes64(b, s[0], 1'b1);
            b = lanes32(b, s[2] >> 24, 1'b1);
            b = arx_inv(b, 2, 3, k[1]);
            b = arx_inv(b, 0, 1, k[0]);
            b = lanes64(b, s[2], 1'b1);
            b = lanes16(b, s[1], 1'b1);
            if (act_dec)
            begin
                db_next.blk = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            da_reg <= da_next;
            db_reg <= db_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = db_reg;
    assign busy      = va_reg | vb_reg;

endmodule

[design/counter_mode_256bit_block_cipher.sv]
// Top level of the counter-mode 256-bit block cipher: config, key store,
// whitening pipeline, round pipeline and output register. Depends on cmb_pkg,
// cmb_round and counter_mode_256bit_block_cipher_assert.svh.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  input   | func, nonce_word, counter_word, in_word*, | in_valid/in_ready
//          | key_round, key_lane                       |
//  output  | out_word0..out_word3                      | out_valid/out_ready
//  config  | cfg_index, cfg_data                       | cfg_we
//
// The pipeline has eight whitening stages, two stages per round slot and one output
// stage. One item enters per cycle while the output is not held.
// A held output freezes the whole pipeline. A key write waits until the
// pipeline is empty. Reset clears valid bits and config; the key store
// holds no reset.
`include "counter_mode_256bit_block_cipher_assert.svh"

module counter_mode_256bit_block_cipher
    import cmb_pkg::*;
#(
    parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] nonce_word,
    input  logic [63:0] counter_word,
    input  logic [63:0] in_word0,
    input  logic [63:0] in_word1,
    input  logic [63:0] in_word2,
    input  logic [63:0] in_word3,
    input  logic [3:0]  key_round,
    input  logic [1:0]  key_lane,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word0,
    output logic [63:0] out_word1,
    output logic [63:0] out_word2,
    output logic [63:0] out_word3,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam int NW = 8;

    logic [4:0]    round_count_reg;
    logic [63:0]   mask_reg [4];
    quad_t         key_reg [MAX_ROUNDS];

    logic          advance;
    logic          busy;
    logic          accept;
    logic          item_in;
    logic [RW+3:0] kr_ext;
    logic [RW-1:0] kr_idx;

    logic [NW-1:0] wv_reg;
    pipe_t         wd_reg [NW];
    pipe_t         wd_next [NW];

    logic          rnd_v [MAX_ROUNDS+1];
    pipe_t         rnd_d [MAX_ROUNDS+1];
    logic [MAX_ROUNDS-1:0] rnd_busy;

    logic          out_v_reg;
    quad_t         out_reg;
    quad_t         out_next;

    assign advance = !out_v_reg || out_ready;
    assign busy    = (|wv_reg) || (|rnd_busy) || out_v_reg;
    assign in_ready = advance && !(func == FUNC_KEY && busy);
    assign accept  = in_valid && in_ready;
    assign item_in = accept && (func == FUNC_ENC || func == FUNC_DEC);
    assign kr_ext  = {{RW{1'b0}}, key_round};
    assign kr_idx  = kr_ext[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= '0;
            for (int j = 0; j < 4; j++)
            begin
                mask_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUNDS: round_count_reg <= cfg_data[4:0];
                REG_MASK0:  mask_reg[0] <= cfg_data;
                REG_MASK1:  mask_reg[1] <= cfg_data;
                REG_MASK2:  mask_reg[2] <= cfg_data;
                REG_MASK3:  mask_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_KEY && 32'(key_round) < MAX_ROUNDS)
        begin
            key_reg[kr_idx][key_lane] <= in_word0;
        end
    end

    // whitening stages
    always_comb
    begin
        wd_next[0].dec    = (func == FUNC_DEC);
        wd_next[0].blk[0] = in_word0;
        wd_next[0].blk[1] = in_word1;
        wd_next[0].blk[2] = in_word2;
        wd_next[0].blk[3] = in_word3;
        wd_next[0].wht[0] = counter_word + mask_reg[0];
        wd_next[0].wht[1] = mask_reg[1];
        wd_next[0].wht[2] = nonce_word + mask_reg[2];
        wd_next[0].wht[3] = mask_reg[3];

        wd_next[1] = wd_reg[0];
        wd_next[1].wht = mul_fwd(wd_reg[0].wht);
        wd_next[2] = wd_reg[1];
        wd_next[2].wht = diffuse(wd_reg[1].wht, 2'd0, 6'd18, DIFF_C0);
        wd_next[3] = wd_reg[2];
        wd_next[3].wht = diffuse(wd_reg[2].wht, 2'd1, 6'd1, DIFF_C1);
        wd_next[4] = wd_reg[3];
        wd_next[4].wht = diffuse(wd_reg[3].wht, 2'd2, 6'd35, DIFF_C2);
        wd_next[5] = wd_reg[4];
        wd_next[5].wht = diffuse(wd_reg[4].wht, 2'd3, 6'd52, DIFF_C3);
        wd_next[6] = wd_reg[5];
        wd_next[6].wht = mul_fwd(wd_reg[5].wht);
        wd_next[7] = wd_reg[6];
        if (!wd_reg[6].dec)
        begin
            wd_next[7].blk = quad_add(wd_reg[6].blk, wd_reg[6].wht);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
        end
        else if (advance)
        begin
            wv_reg <= {wv_reg[NW-2:0], item_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NW; i++)
            begin
                wd_reg[i] <= wd_next[i];
            end
        end
    end

    assign rnd_v[0] = wv_reg[NW-1];
    assign rnd_d[0] = wd_reg[NW-1];

    for (genvar p = 0; p < MAX_ROUNDS; p++)
    begin : g_round
        cmb_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (rnd_v[p]),
            .in_data   (rnd_d[p]),
            .key_enc   (key_reg[p]),
            .key_dec   (key_reg[MAX_ROUNDS-1-p]),
            .act_enc   (p < 32'(round_count_reg)),
            .act_dec   ((MAX_ROUNDS - 1 - p) < 32'(round_count_reg)),
            .out_valid (rnd_v[p+1]),
            .out_data  (rnd_d[p+1]),
            .busy      (rnd_busy[p])
        );
    end

    assign out_next = rnd_d[MAX_ROUNDS].dec ?
                      quad_sub(rnd_d[MAX_ROUNDS].blk, rnd_d[MAX_ROUNDS].wht) :
                      rnd_d[MAX_ROUNDS].blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= rnd_v[MAX_ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_word0 = out_reg[0];
    assign out_word1 = out_reg[1];
    assign out_word2 = out_reg[2];
    assign out_word3 = out_reg[3];

    `CMB_ASSERT_IMP(a_key_on_empty, clk, rst_n, accept && func == FUNC_KEY, !busy, "key write while items in flight")
    `CMB_ASSERT_NXT(a_stall_holds, clk, rst_n, !advance, $stable(wv_reg) && $stable(out_reg), "pipeline moved during stall")
    `CMB_ASSERT_NXT(a_no_item_drop, clk, rst_n, accept && func != FUNC_ENC && func != FUNC_DEC, !wv_reg[0], "non-block item entered pipeline")

endmodule

[test/cmb_checker.sv]
// Checker for the counter-mode 256-bit block cipher: watches the item, result
// and register ports, predicts each result and compares it. Depends on cmb_pkg.
module cmb_checker
    import cmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] nonce_word,
    input  logic [63:0] counter_word,
    input  logic [63:0] in_word0,
    input  logic [63:0] in_word1,
    input  logic [63:0] in_word2,
    input  logic [63:0] in_word3,
    input  logic [3:0]  key_round,
    input  logic [1:0]  key_lane,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] out_word0,
    input  logic [63:0] out_word1,
    input  logic [63:0] out_word2,
    input  logic [63:0] out_word3,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int NROUNDS = 16;

    logic [63:0] key_tab [NROUNDS*4];
    logic [4:0]  rounds_reg;
    quad_t       mask;
    quad_t       block_q [$];

    function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
        int m;
        m = r & 63;
        if (m == 0)
        begin
            return x;
        end
        return (x << m) | (x >> (64 - m));
    endfunction

    function automatic logic [31:0] rot32(input logic [31:0] x, input int r);
        int m;
        m = r & 31;
        if (m == 0)
        begin
            return x;
        end
        return (x << m) | (x >> (32 - m));
    endfunction

    function automatic logic [15:0] rot16(input logic [15:0] x, input int r);
        int m;
        m = r & 15;
        if (m == 0)
        begin
            return x;
        end
        return (x << m) | (x >> (16 - m));
    endfunction

    function automatic quad_t spin16(input quad_t w, input logic [63:0] s, input bit inv);
        int amt;
        for (int k = 0; k < 16; k++)
        begin
            amt = s[4*k +: 4];
            if (inv)
            begin
                amt = (16 - amt) & 15;
            end
            w[k/4][16*(k%4) +: 16] = rot16(w[k/4][16*(k%4) +: 16], amt);
        end
        return w;
    endfunction

    function automatic quad_t spin32(input quad_t w, input logic [63:0] s, input bit inv);
        int amt;
        for (int k = 0; k < 8; k++)
        begin
            amt = s[5*k +: 5];
            if (inv)
            begin
                amt = (32 - amt) & 31;
            end
            w[k/2][32*(k%2) +: 32] = rot32(w[k/2][32*(k%2) +: 32], amt);
        end
        return w;
    endfunction

    function automatic quad_t spin64(input quad_t w, input logic [63:0] s, input bit inv);
        int amt;
        for (int k = 0; k < 4; k++)
        begin
            amt = s[6*k +: 6];
            if (inv)
            begin
                amt = (64 - amt) & 63;
            end
            w[k] = rot64(w[k], amt);
        end
        return w;
    endfunction

    function automatic quad_t mix_fwd(input quad_t w, input int x, input int y,
                                      input logic [63:0] k);
        w[x] = (rot64(w[x], 56) + w[y]) ^ k;
        w[y] = rot64(w[y], 3) ^ w[x];
        return w;
    endfunction

    function automatic quad_t mix_inv(input quad_t w, input int x, input int y,
                                      input logic [63:0] k);
        w[y] = rot64(w[y] ^ w[x], 61);
        w[x] = rot64((w[x] ^ k) - w[y], 8);
        return w;
    endfunction

    function automatic quad_t matrix_fwd(input quad_t a);
        quad_t t;
        t[0] = 64'd0 - 64'd3 * a[0] - a[1] - 64'd5 * a[3];
        t[1] = 64'd7 * a[0] + 64'd3 * a[1] + a[2] + 64'd12 * a[3];
        t[2] = 64'd0 - 64'd2 * a[0] - a[1] - 64'd4 * a[3];
        t[3] = 64'd9 * a[0] + 64'd4 * a[1] + a[2] + 64'd15 * a[3];
        return t;
    endfunction

    function automatic quad_t matrix_inv(input quad_t a);
        quad_t t;
        t[0] = 64'd0 - a[0] - a[1] + 64'd2 * a[2] + a[3];
        t[1] = 64'd2 * a[0] - 64'd2 * a[1] - a[2] + 64'd2 * a[3];
        t[2] = a[0] + 64'd2 * a[1] + a[2] - a[3];
        t[3] = a[1] - a[2] - a[3];
        return t;
    endfunction

    function automatic quad_t stir(input quad_t w, input int i, input int r,
                                   input logic [63:0] c);
        int ib;
        int ic;
        int id;
        ib = (i + 1) % 4;
        ic = (i + 2) % 4;
        id = (i + 3) % 4;
        w[i]  = w[i] + rot64(w[ib], 5) - w[ib];
        w[ic] = w[ic] ^ (w[id] + c);
        w[ib] = rot64(w[ib], 8);
        w[id] = w[id] + w[i];
        w[i]  = rot64(w[i], r);
        return w;
    endfunction

    function automatic quad_t whiten(input logic [63:0] nonce, input logic [63:0] ctr);
        quad_t c;
        c[0] = ctr + mask[0];
        c[1] = mask[1];
        c[2] = nonce + mask[2];
        c[3] = mask[3];
        c = matrix_fwd(c);
        c = stir(c, 0, 18, DIFF_C0);
        c = stir(c, 1, 1, DIFF_C1);
        c = stir(c, 2, 35, DIFF_C2);
        c = stir(c, 3, 52, DIFF_C3);
        return matrix_fwd(c);
    endfunction

    function automatic quad_t cipher_block(input bit dec, input quad_t b, input quad_t wd);
        quad_t k;
        quad_t s;
        int    nr;
        nr = (rounds_reg > NROUNDS) ? NROUNDS : int'(rounds_reg);
        if (!dec)
        begin
            for (int j = 0; j < 4; j++)
            begin
                b[j] = b[j] + wd[j];
            end
            for (int r = 0; r < nr; r++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    k[j] = key_tab[r*4 + j];
                    s[j] = wd[j] ^ k[j];
                end
                b = spin16(b, s[1], 0);
                b = spin64(b, s[2], 0);
                b = mix_fwd(b, 0, 1, k[0]);
                b = mix_fwd(b, 2, 3, k[1]);
                b = spin32(b, s[2] >> 24, 0);
                b = spin64(b, s[0], 0);
                b = mix_fwd(b, 2, 1, k[3]);
                b = mix_fwd(b, 0, 3, k[2]);
                b = spin16(b, s[3], 0);
                b = spin32(b, s[0] >> 24, 0);
                b = matrix_fwd(b);
                for (int j = 0; j < 4; j++)
                begin
                    b[j] = b[j] + k[j];
                end
            end
        end
        else
        begin
            for (int r = nr - 1; r >= 0; r--)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    k[j] = key_tab[r*4 + j];
                    s[j] = wd[j] ^ k[j];
                    b[j] = b[j] - k[j];
                end
                b = matrix_inv(b);
                b = spin32(b, s[0] >> 24, 1);
                b = spin16(b, s[3], 1);
                b = mix_inv(b, 0, 3, k[2]);
                b = mix_inv(b, 2, 1, k[3]);
                b = spin64(b, s[0], 1);
                b = spin32(b, s[2] >> 24, 1);
                b = mix_inv(b, 2, 3, k[1]);
                b = mix_inv(b, 0, 1, k[0]);
                b = spin64(b, s[2], 1);
                b = spin16(b, s[1], 1);
            end
            for (int j = 0; j < 4; j++)
            begin
                b[j] = b[j] - wd[j];
            end
        end
        return b;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        quad_t blk;
        quad_t exp_blk;
        quad_t got;
        if (!rst_n)
        begin
            rounds_reg = '0;
            mask = '0;
            block_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROUNDS: rounds_reg = cfg_data[4:0];
                    REG_MASK0:  mask[0] = cfg_data;
                    REG_MASK1:  mask[1] = cfg_data;
                    REG_MASK2:  mask[2] = cfg_data;
                    REG_MASK3:  mask[3] = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {out_word3, out_word2, out_word1, out_word0};
                if (block_q.size() == 0)
                begin
                    $error("result with no item pending: %h", got);
                    fail_count++;
                end
                else
                begin
                    exp_blk = block_q.pop_front();
                    for (int j = 0; j < 4; j++)
                    begin
                        if (got[j] !== exp_blk[j])
                        begin
                            $error("out_word%0d mismatch: expected %h actual %h",
                                   j, exp_blk[j], got[j]);
                            fail_count++;
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (func == FUNC_KEY)
                begin
                    key_tab[key_round*4 + key_lane] = in_word0;
                end
                else if (func == FUNC_ENC || func == FUNC_DEC)
                begin
                    blk = {in_word3, in_word2, in_word1, in_word0};
                    block_q.push_back(cipher_block(func == FUNC_DEC, blk,
                                                   whiten(nonce_word, counter_word)));
                end
            end
        end
        pending = block_q.size();
    end

endmodule

[test/tb_counter_mode_256bit_block_cipher.sv]
// Testbench top for the counter-mode 256-bit block cipher: clock, reset,
// stimulus and verdict. Depends on cmb_pkg, cmb_checker and the block itself.
module tb_counter_mode_256bit_block_cipher;
    import cmb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_GAP  = 60;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [63:0] nonce_word;
    logic [63:0] counter_word;
    logic [63:0] in_word0;
    logic [63:0] in_word1;
    logic [63:0] in_word2;
    logic [63:0] in_word3;
    logic [3:0]  key_round;
    logic [1:0]  key_lane;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int fail_count;
    int pending;
    int send_idle;
    int recv_stall;
    bit hold_req;
    int hold_cnt;
    int quiet_cycles;
    int n_enc;
    int n_dec;
    int n_key;

    counter_mode_256bit_block_cipher i_dut (.*);

    cmb_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send(input logic [1:0] f, input logic [63:0] n, input logic [63:0] c,
                        input logic [63:0] w0, input logic [63:0] w1,
                        input logic [63:0] w2, input logic [63:0] w3,
                        input logic [3:0] kr, input logic [1:0] kl);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        func <= f;
        nonce_word <= n;
        counter_word <= c;
        in_word0 <= w0;
        in_word1 <= w1;
        in_word2 <= w2;
        in_word3 <= w3;
        key_round <= kr;
        key_lane <= kl;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        case (f)
            FUNC_ENC: n_enc++;
            FUNC_DEC: n_dec++;
            FUNC_KEY: n_key++;
            default: ;
        endcase
    endtask

    task automatic send_random();
        int          pick;
        logic [1:0]  f;
        pick = $urandom_range(99);
        if (pick < 44)
        begin
            f = FUNC_ENC;
        end
        else if (pick < 88)
        begin
            f = FUNC_DEC;
        end
        else if (pick < 95)
        begin
            f = FUNC_KEY;
        end
        else
        begin
            f = 2'd3;
        end
        send(f, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word(), 4'($urandom), 2'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_masks(input int kind);
        logic [63:0] m;
        for (int j = 0; j < 4; j++)
        begin
            m = (kind == 0) ? 64'd0 : (kind == 1) ? '1 : {$urandom, $urandom};
            write_reg(REG_MASK0 + 3'(j), m);
        end
    endtask

    initial
    begin
        int rc_list [6];
        int mk_list [6];
        int rc;
        rc_list = '{16, 0, 1, 31, 9, 16};
        mk_list = '{2, 0, 1, 2, 2, 1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = FUNC_ENC;
        nonce_word = '0;
        counter_word = '0;
        in_word0 = '0;
        in_word1 = '0;
        in_word2 = '0;
        in_word3 = '0;
        key_round = '0;
        key_lane = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ROUNDS;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        quiet_cycles = 0;
        n_enc = 0;
        n_dec = 0;
        n_key = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the whole key table before any block reads it
        for (int r = 0; r < 16; r++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                send(FUNC_KEY, '0, '0, rand_word(), '0, '0, '0, 4'(r), 2'(l));
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            drain();
            rc = (p == 4) ? $urandom_range(15, 2) : rc_list[p];
            write_reg(REG_ROUNDS, 64'(rc));
            set_masks(mk_list[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 52; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 52; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            if (p == 2)
            begin
                hold_req = 1'b1;
            end
            if (p < 2)
            begin
                send(FUNC_ENC, '0, '0, '0, '0, '0, '0, '0, '0);
                send(FUNC_ENC, '1, '1, '1, '1, '1, '1, '1, '1);
                send(FUNC_DEC, '0, '0, '0, '0, '0, '0, '0, '0);
                send(FUNC_DEC, '1, '1, '1, '1, '1, '1, '1, '1);
                send(2'd3, '1, '1, '1, '1, '1, '1, '1, '1);
                send(FUNC_KEY, '1, '1, '1, '1, '1, '1, 4'd15, 2'd3);
                send(FUNC_KEY, '0, '0, '0, '0, '0, '0, 4'd0, 2'd0);
                send(FUNC_ENC, '1, '0, 64'h8000000000000001, '0, '1, 64'h1, '0, '0);
                send(FUNC_DEC, '0, '1, '0, '1, 64'h1, '1, '0, '0);
            end
            for (int i = 0; i < 200; i++)
            begin
                send_random();
            end
        end
        drain();

        $display("Covered %0d encrypt, %0d decrypt and %0d key-write items", n_enc, n_dec,
                 n_key);
        $display("over six register settings, four idling modes and one long output stall.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
